/* rtl/core/wemv_pkg.sv */
// Shared constants, codes and interface types of the running mean and variance core.
`timescale 1ns / 1ps

package wemv_pkg;

   localparam int SAMPLE_BITS = 16;
   localparam int FRAC_BITS   = 16;
   localparam int MEAN_BITS   = SAMPLE_BITS + FRAC_BITS;
   localparam int VAR_BITS    = 48;
   localparam int SUM_BITS    = 64;
   localparam int CFG_BITS    = 16;
   localparam int CNT_BITS    = 16;
   localparam int MAG_BITS    = 32;

   // shared shift/add unit
   localparam int ALU_OPND_BITS = 48;
   localparam int ALU_ADD_BITS  = ALU_OPND_BITS + 1;
   localparam int ALU_LO_BITS   = 64;
   localparam int ALU_DIV_BITS  = CNT_BITS;
   localparam int ALU_STEP_BITS = 6;

   localparam logic [ALU_STEP_BITS-1:0] MUL_STEPS_WIDE   = 6'd32;
   localparam logic [ALU_STEP_BITS-1:0] MUL_STEPS_NARROW = 6'd16;
   localparam logic [ALU_STEP_BITS-1:0] DIV_STEPS_MEAN   = 6'd32;
   localparam logic [ALU_STEP_BITS-1:0] DIV_STEPS_VAR    = 6'd48;

   localparam logic [VAR_BITS-1:0]  VAR_MAX      = 48'hFFFF_FFFF_FFFF;
   localparam logic [MEAN_BITS-1:0] MEAN_MAX     = 32'h7FFF_FFFF;
   localparam logic [MEAN_BITS-1:0] MEAN_MIN     = 32'h8000_0000;
   localparam logic [CFG_BITS-1:0]  WINDOW_RESET = 16'd16;
   localparam logic [CFG_BITS-1:0]  ALPHA_RESET  = 16'd7710;
   localparam logic [CFG_BITS:0]    ALPHA_ONE    = 17'h1_0000;

   localparam int CSR_INDEX_BITS = 1;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_WINDOW_SIZE,
      CSR_ALPHA
   } csr_index_type;

   typedef enum logic {
      OP_MUL,
      OP_DIV
   } alu_op_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DELTA,
      ST_MEAN_DIV,
      ST_DELTA2,
      ST_SQ_MUL,
      ST_VAR_LAUNCH,
      ST_VAR_DIV,
      ST_STEP_MUL,
      ST_SQ2_MUL,
      ST_T_MUL,
      ST_DECAY_MUL,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic                     start;
      alu_op_type               op;
      logic [ALU_STEP_BITS-1:0] steps;
      logic [ALU_OPND_BITS-1:0] operand;
      logic [ALU_OPND_BITS-1:0] hi_init;
      logic [ALU_LO_BITS-1:0]   lo_init;
   } alu_cmd_type;

   typedef struct packed {
      logic                     busy;
      logic                     done;
      logic [ALU_OPND_BITS-1:0] hi;
      logic [ALU_LO_BITS-1:0]   lo;
   } alu_res_type;

   typedef struct packed {
      logic [CFG_BITS-1:0] window_size;
      logic [CFG_BITS-1:0] alpha;
   } cfg_type;

endpackage

/* rtl/core/wemv_alu.sv */
// Shared shift-add multiplier and restoring divider, one bit per cycle.
`timescale 1ns / 1ps

module wemv_alu (
   input  logic                  clock,
   input  logic                  reset,
   input  wemv_pkg::alu_cmd_type alu_cmd,
   output wemv_pkg::alu_res_type alu_res
);

   logic                               busy_ff, busy_in;
   logic                               done_ff, done_in;
   logic [wemv_pkg::ALU_STEP_BITS-1:0] cnt_ff, cnt_in;
   wemv_pkg::alu_op_type               op_ff, op_in;
   logic [wemv_pkg::ALU_OPND_BITS-1:0] operand_ff, operand_in;
   logic [wemv_pkg::ALU_OPND_BITS-1:0] hi_ff, hi_in, hi_step;
   logic [wemv_pkg::ALU_LO_BITS-1:0]   lo_ff, lo_in, lo_step;

   logic [wemv_pkg::ALU_ADD_BITS-1:0]  a_op, b_op;
   logic                               carry_in;
   logic [wemv_pkg::ALU_ADD_BITS:0]    add_sum;

   // operand selection for the single adder
   always_comb begin
      a_op     = '0;
      b_op     = '0;
      carry_in = 1'b0;
      case (op_ff)
         wemv_pkg::OP_MUL: begin
            a_op = {1'b0, hi_ff};
            b_op = lo_ff[0] ? {1'b0, operand_ff} : '0;
         end
         wemv_pkg::OP_DIV: begin
            // trial subtract of the divisor from the partial remainder
            a_op     = {hi_ff, lo_ff[wemv_pkg::ALU_LO_BITS-1]};
            b_op     = ~{{(wemv_pkg::ALU_ADD_BITS-wemv_pkg::ALU_DIV_BITS){1'b0}},
                         operand_ff[wemv_pkg::ALU_DIV_BITS-1:0]};
            carry_in = 1'b1;
         end
         default: begin
            a_op = '0;
         end
      endcase
   end

   assign add_sum = {1'b0, a_op} + {1'b0, b_op}
                    + {{wemv_pkg::ALU_ADD_BITS{1'b0}}, carry_in};

   always_comb begin
      hi_step = hi_ff;
      lo_step = lo_ff;
      case (op_ff)
         wemv_pkg::OP_MUL: begin
            hi_step = add_sum[wemv_pkg::ALU_ADD_BITS-1:1];
            lo_step = {lo_ff[wemv_pkg::ALU_LO_BITS-1:32], add_sum[0], lo_ff[31:1]};
         end
         wemv_pkg::OP_DIV: begin
            // carry out set means no borrow: quotient bit is one
            hi_step = add_sum[wemv_pkg::ALU_ADD_BITS] ?
                      add_sum[wemv_pkg::ALU_OPND_BITS-1:0] :
                      a_op[wemv_pkg::ALU_OPND_BITS-1:0];
            lo_step = {lo_ff[wemv_pkg::ALU_LO_BITS-2:0], add_sum[wemv_pkg::ALU_ADD_BITS]};
         end
         default: begin
            hi_step = hi_ff;
         end
      endcase
   end

   always_comb begin
      busy_in    = busy_ff;
      cnt_in     = cnt_ff;
      op_in      = op_ff;
      operand_in = operand_ff;
      hi_in      = hi_ff;
      lo_in      = lo_ff;
      done_in    = busy_ff && (cnt_ff == wemv_pkg::ALU_STEP_BITS'(1));
      if (alu_cmd.start) begin
         busy_in    = 1'b1;
         cnt_in     = alu_cmd.steps;
         op_in      = alu_cmd.op;
         operand_in = alu_cmd.operand;
         hi_in      = alu_cmd.hi_init;
         lo_in      = alu_cmd.lo_init;
      end else if (busy_ff) begin
         hi_in  = hi_step;
         lo_in  = lo_step;
         cnt_in = cnt_ff - wemv_pkg::ALU_STEP_BITS'(1);
         if (cnt_ff == wemv_pkg::ALU_STEP_BITS'(1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff      <= op_in;
      operand_ff <= operand_in;
      hi_ff      <= hi_in;
      lo_ff      <= lo_in;
   end

   assign alu_res.busy = busy_ff;
   assign alu_res.done = done_ff;
   assign alu_res.hi   = hi_ff;
   assign alu_res.lo   = lo_ff;

   a_start_when_idle: assert property (@(posedge clock) disable iff (reset)
      alu_cmd.start |-> !busy_ff)
      else $error("unit started while an operation is running");

   a_done_after_run: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(busy_ff))
      else $error("done raised without a preceding run");

   a_steps_nonzero: assert property (@(posedge clock) disable iff (reset)
      alu_cmd.start |-> (alu_cmd.steps != '0))
      else $error("operation started with no steps");

endmodule

/* rtl/core/wemv_ctrl.sv */
// Sequencer and state of the Welford / EWMA update, with the result register.
`timescale 1ns / 1ps

module wemv_ctrl (
   input  logic                                clock,
   input  logic                                reset,
   input  wemv_pkg::cfg_type                   cfg,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic signed [wemv_pkg::SAMPLE_BITS-1:0] req_sample,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [wemv_pkg::MEAN_BITS-1:0]   rsp_mean,
   output logic [wemv_pkg::VAR_BITS-1:0]       rsp_variance,
   output logic                                rsp_filling,
   output wemv_pkg::alu_cmd_type               alu_cmd,
   input  wemv_pkg::alu_res_type               alu_res
);

   wemv_pkg::state_type state_ff, state_in;

   logic [wemv_pkg::MEAN_BITS-1:0] x_ff, x_in;
   logic                           fill_ff, fill_in;
   logic [wemv_pkg::CNT_BITS-1:0]  seen_ff, seen_in;
   logic [wemv_pkg::MEAN_BITS-1:0] mean_ff, mean_in;
   logic [wemv_pkg::SUM_BITS-1:0]  ss_ff, ss_in;
   logic [wemv_pkg::VAR_BITS-1:0]  var_ff, var_in;
   logic [wemv_pkg::MAG_BITS-1:0]  dm1_ff, dm1_in;
   logic                           neg1_ff, neg1_in;
   logic                           neg2_ff, neg2_in;
   logic                           zero2_ff, zero2_in;

   logic                           rsp_valid_ff, rsp_valid_in;
   logic [wemv_pkg::MEAN_BITS-1:0] rsp_mean_ff, rsp_mean_in;
   logic [wemv_pkg::VAR_BITS-1:0]  rsp_var_ff, rsp_var_in;
   logic                           rsp_fill_ff, rsp_fill_in;

   logic [wemv_pkg::MEAN_BITS-1:0] x_now;
   logic                           fill_now;
   logic                           accept;
   logic                           alu_done;
   logic                           out_free;
   logic                           var_sat;
   logic [wemv_pkg::MEAN_BITS:0]   diff, diff_neg;
   logic [wemv_pkg::MAG_BITS-1:0]  diff_mag;
   logic [wemv_pkg::MAG_BITS-1:0]  step_mag;
   logic [wemv_pkg::MEAN_BITS+1:0] mean_ext, step_ext, mean_sum;
   logic [wemv_pkg::MEAN_BITS-1:0] mean_adj;
   logic [wemv_pkg::VAR_BITS-1:0]  prod_sq;
   logic [wemv_pkg::SUM_BITS:0]    ss_sum;
   logic [wemv_pkg::SUM_BITS-1:0]  ss_sat, ss_sub;
   logic                           ss_down;
   logic [wemv_pkg::VAR_BITS:0]    var_sum;
   logic [wemv_pkg::VAR_BITS-1:0]  var_sum_sat;
   logic [wemv_pkg::CFG_BITS-1:0]  alpha_comp;

   function automatic logic [wemv_pkg::MEAN_BITS-1:0] clamp_mean(
      input logic [wemv_pkg::MEAN_BITS+1:0] v
   );
      logic [2:0] top;
      top = v[wemv_pkg::MEAN_BITS+1:wemv_pkg::MEAN_BITS-1];
      if (top == 3'b000 || top == 3'b111) begin
         return v[wemv_pkg::MEAN_BITS-1:0];
      end else if (!v[wemv_pkg::MEAN_BITS+1]) begin
         return wemv_pkg::MEAN_MAX;
      end else begin
         return wemv_pkg::MEAN_MIN;
      end
   endfunction

   assign x_now    = {req_sample, {wemv_pkg::FRAC_BITS{1'b0}}};
   assign fill_now = seen_ff < cfg.window_size;
   assign accept   = req_valid && req_ready;
   assign alu_done = alu_res.done;
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign var_sat  = ss_ff[wemv_pkg::SUM_BITS-1:wemv_pkg::VAR_BITS] >= seen_ff;

   // signed difference x - mean and its magnitude
   assign diff     = {x_ff[wemv_pkg::MEAN_BITS-1], x_ff}
                     - {mean_ff[wemv_pkg::MEAN_BITS-1], mean_ff};
   assign diff_neg = '0 - diff;
   assign diff_mag = diff[wemv_pkg::MEAN_BITS] ? diff_neg[wemv_pkg::MAG_BITS-1:0]
                                               : diff[wemv_pkg::MAG_BITS-1:0];

   // mean moved by a magnitude in the direction of the first difference
   assign step_mag = (state_ff == wemv_pkg::ST_MEAN_DIV) ?
                     alu_res.lo[wemv_pkg::MAG_BITS-1:0] :
                     alu_res.hi[wemv_pkg::MAG_BITS-1:0];
   assign mean_ext = {{2{mean_ff[wemv_pkg::MEAN_BITS-1]}}, mean_ff};
   assign step_ext = {2'b00, step_mag};
   assign mean_sum = neg1_ff ? (mean_ext - step_ext) : (mean_ext + step_ext);
   assign mean_adj = clamp_mean(mean_sum);

   // 32-step product taken down by the fraction bits
   assign prod_sq = {alu_res.hi[wemv_pkg::MAG_BITS-1:0],
                     alu_res.lo[wemv_pkg::MAG_BITS-1:wemv_pkg::FRAC_BITS]};

   assign ss_sum  = {1'b0, ss_ff} + {{(wemv_pkg::SUM_BITS-wemv_pkg::VAR_BITS+1){1'b0}}, prod_sq};
   assign ss_sat  = ss_sum[wemv_pkg::SUM_BITS] ? '1 : ss_sum[wemv_pkg::SUM_BITS-1:0];
   assign ss_sub  = ({{(wemv_pkg::SUM_BITS-wemv_pkg::VAR_BITS){1'b0}}, prod_sq} > ss_ff) ? '0 :
                    ss_ff - {{(wemv_pkg::SUM_BITS-wemv_pkg::VAR_BITS){1'b0}}, prod_sq};
   assign ss_down = (neg1_ff != neg2_ff) && (dm1_ff != '0) && !zero2_ff;

   assign var_sum     = {1'b0, var_ff} + {1'b0, alu_res.hi};
   assign var_sum_sat = var_sum[wemv_pkg::VAR_BITS] ? wemv_pkg::VAR_MAX
                                                    : var_sum[wemv_pkg::VAR_BITS-1:0];
   assign alpha_comp  = wemv_pkg::CFG_BITS'(wemv_pkg::ALPHA_ONE - {1'b0, cfg.alpha});

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         wemv_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = (fill_now && seen_ff == '0) ? wemv_pkg::ST_DONE : wemv_pkg::ST_DELTA;
            end
         end
         wemv_pkg::ST_DELTA: begin
            state_in = fill_ff ? wemv_pkg::ST_MEAN_DIV : wemv_pkg::ST_STEP_MUL;
         end
         wemv_pkg::ST_MEAN_DIV: begin
            if (alu_done) state_in = wemv_pkg::ST_DELTA2;
         end
         wemv_pkg::ST_DELTA2: begin
            state_in = wemv_pkg::ST_SQ_MUL;
         end
         wemv_pkg::ST_SQ_MUL: begin
            if (alu_done) state_in = wemv_pkg::ST_VAR_LAUNCH;
         end
         wemv_pkg::ST_VAR_LAUNCH: begin
            state_in = var_sat ? wemv_pkg::ST_DONE : wemv_pkg::ST_VAR_DIV;
         end
         wemv_pkg::ST_VAR_DIV: begin
            if (alu_done) state_in = wemv_pkg::ST_DONE;
         end
         wemv_pkg::ST_STEP_MUL: begin
            if (alu_done) state_in = wemv_pkg::ST_SQ2_MUL;
         end
         wemv_pkg::ST_SQ2_MUL: begin
            if (alu_done) state_in = wemv_pkg::ST_T_MUL;
         end
         wemv_pkg::ST_T_MUL: begin
            if (alu_done) begin
               state_in = (cfg.alpha == '0) ? wemv_pkg::ST_DONE : wemv_pkg::ST_DECAY_MUL;
            end
         end
         wemv_pkg::ST_DECAY_MUL: begin
            if (alu_done) state_in = wemv_pkg::ST_DONE;
         end
         wemv_pkg::ST_DONE: begin
            if (out_free) state_in = wemv_pkg::ST_IDLE;
         end
         default: begin
            state_in = wemv_pkg::ST_IDLE;
         end
      endcase
   end

   // handshake and unit commands
   always_comb begin
      req_ready       = 1'b0;
      alu_cmd.start   = 1'b0;
      alu_cmd.op      = wemv_pkg::OP_MUL;
      alu_cmd.steps   = wemv_pkg::MUL_STEPS_WIDE;
      alu_cmd.operand = '0;
      alu_cmd.hi_init = '0;
      alu_cmd.lo_init = '0;
      case (state_ff)
         wemv_pkg::ST_IDLE: begin
            req_ready = 1'b1;
         end
         wemv_pkg::ST_DELTA: begin
            alu_cmd.start = 1'b1;
            if (fill_ff) begin
               alu_cmd.op      = wemv_pkg::OP_DIV;
               alu_cmd.steps   = wemv_pkg::DIV_STEPS_MEAN;
               alu_cmd.operand = {{(wemv_pkg::ALU_OPND_BITS-wemv_pkg::CNT_BITS){1'b0}}, seen_ff};
               alu_cmd.lo_init = {diff_mag, {(wemv_pkg::ALU_LO_BITS-wemv_pkg::MAG_BITS){1'b0}}};
            end else begin
               alu_cmd.steps   = wemv_pkg::MUL_STEPS_NARROW;
               alu_cmd.operand = {{(wemv_pkg::ALU_OPND_BITS-wemv_pkg::MAG_BITS){1'b0}}, diff_mag};
               alu_cmd.lo_init = {{(wemv_pkg::ALU_LO_BITS-wemv_pkg::CFG_BITS){1'b0}}, cfg.alpha};
            end
         end
         wemv_pkg::ST_DELTA2: begin
            alu_cmd.start   = 1'b1;
            alu_cmd.operand = {{(wemv_pkg::ALU_OPND_BITS-wemv_pkg::MAG_BITS){1'b0}}, dm1_ff};
            alu_cmd.lo_init = {{(wemv_pkg::ALU_LO_BITS-wemv_pkg::MAG_BITS){1'b0}}, diff_mag};
         end
         wemv_pkg::ST_VAR_LAUNCH: begin
            // top quotient bits are known zero here, so only the low 48 are worked out
            alu_cmd.start   = !var_sat;
            alu_cmd.op      = wemv_pkg::OP_DIV;
            alu_cmd.steps   = wemv_pkg::DIV_STEPS_VAR;
            alu_cmd.operand = {{(wemv_pkg::ALU_OPND_BITS-wemv_pkg::CNT_BITS){1'b0}}, seen_ff};
            alu_cmd.hi_init = {{(wemv_pkg::ALU_OPND_BITS-wemv_pkg::CNT_BITS){1'b0}},
                               ss_ff[wemv_pkg::SUM_BITS-1:wemv_pkg::VAR_BITS]};
            alu_cmd.lo_init = {ss_ff[wemv_pkg::VAR_BITS-1:0],
                               {(wemv_pkg::ALU_LO_BITS-wemv_pkg::VAR_BITS){1'b0}}};
         end
         wemv_pkg::ST_STEP_MUL: begin
            alu_cmd.start   = alu_done;
            alu_cmd.operand = {{(wemv_pkg::ALU_OPND_BITS-wemv_pkg::MAG_BITS){1'b0}}, dm1_ff};
            alu_cmd.lo_init = {{(wemv_pkg::ALU_LO_BITS-wemv_pkg::MAG_BITS){1'b0}}, dm1_ff};
         end
         wemv_pkg::ST_SQ2_MUL: begin
            alu_cmd.start   = alu_done;
            alu_cmd.steps   = wemv_pkg::MUL_STEPS_NARROW;
            alu_cmd.operand = prod_sq;
            alu_cmd.lo_init = {{(wemv_pkg::ALU_LO_BITS-wemv_pkg::CFG_BITS){1'b0}}, cfg.alpha};
         end
         wemv_pkg::ST_T_MUL: begin
            // weight 1 - alpha; a zero alpha keeps the sum as it is
            alu_cmd.start   = alu_done && (cfg.alpha != '0);
            alu_cmd.steps   = wemv_pkg::MUL_STEPS_NARROW;
            alu_cmd.operand = var_sum_sat;
            alu_cmd.lo_init = {{(wemv_pkg::ALU_LO_BITS-wemv_pkg::CFG_BITS){1'b0}}, alpha_comp};
         end
         default: begin
            alu_cmd.start = 1'b0;
         end
      endcase
   end

   // datapath next values
   always_comb begin
      x_in        = x_ff;
      fill_in     = fill_ff;
      seen_in     = seen_ff;
      mean_in     = mean_ff;
      ss_in       = ss_ff;
      var_in      = var_ff;
      dm1_in      = dm1_ff;
      neg1_in     = neg1_ff;
      neg2_in     = neg2_ff;
      zero2_in    = zero2_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_mean_in = rsp_mean_ff;
      rsp_var_in  = rsp_var_ff;
      rsp_fill_in = rsp_fill_ff;
      case (state_ff)
         wemv_pkg::ST_IDLE: begin
            if (accept) begin
               x_in    = x_now;
               fill_in = fill_now;
               if (fill_now) begin
                  seen_in = seen_ff + wemv_pkg::CNT_BITS'(1);
                  if (seen_ff == '0) begin
                     mean_in = x_now;
                     ss_in   = '0;
                     var_in  = '0;
                  end
               end
            end
         end
         wemv_pkg::ST_DELTA: begin
            dm1_in  = diff_mag;
            neg1_in = diff[wemv_pkg::MEAN_BITS];
         end
         wemv_pkg::ST_MEAN_DIV: begin
            if (alu_done) mean_in = mean_adj;
         end
         wemv_pkg::ST_DELTA2: begin
            neg2_in  = diff[wemv_pkg::MEAN_BITS];
            zero2_in = (diff_mag == '0);
         end
         wemv_pkg::ST_SQ_MUL: begin
            if (alu_done) ss_in = ss_down ? ss_sub : ss_sat;
         end
         wemv_pkg::ST_VAR_LAUNCH: begin
            if (var_sat) var_in = wemv_pkg::VAR_MAX;
         end
         wemv_pkg::ST_VAR_DIV: begin
            if (alu_done) var_in = alu_res.lo[wemv_pkg::VAR_BITS-1:0];
         end
         wemv_pkg::ST_STEP_MUL: begin
            if (alu_done) mean_in = mean_adj;
         end
         wemv_pkg::ST_T_MUL: begin
            if (alu_done && cfg.alpha == '0) var_in = var_sum_sat;
         end
         wemv_pkg::ST_DECAY_MUL: begin
            if (alu_done) var_in = alu_res.hi;
         end
         wemv_pkg::ST_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_mean_in  = mean_ff;
               rsp_var_in   = var_ff;
               rsp_fill_in  = fill_ff;
            end
         end
         default: begin
            x_in = x_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= wemv_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
         seen_ff      <= '0;
         mean_ff      <= '0;
         ss_ff        <= '0;
         var_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         seen_ff      <= seen_in;
         mean_ff      <= mean_in;
         ss_ff        <= ss_in;
         var_ff       <= var_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff        <= x_in;
      fill_ff     <= fill_in;
      dm1_ff      <= dm1_in;
      neg1_ff     <= neg1_in;
      neg2_ff     <= neg2_in;
      zero2_ff    <= zero2_in;
      rsp_mean_ff <= rsp_mean_in;
      rsp_var_ff  <= rsp_var_in;
      rsp_fill_ff <= rsp_fill_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_mean     = rsp_mean_ff;
   assign rsp_variance = rsp_var_ff;
   assign rsp_filling  = rsp_fill_ff;

   a_fill_counts: assert property (@(posedge clock) disable iff (reset)
      (accept && fill_now) |=> (seen_ff == $past(seen_ff) + wemv_pkg::CNT_BITS'(1)))
      else $error("sample count did not advance on a fill transfer");

   a_done_unit_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == wemv_pkg::ST_DONE) |-> !alu_res.busy)
      else $error("result stage reached with the unit still running");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == wemv_pkg::ST_DONE))
      else $error("result raised outside the completion step");

endmodule

/* rtl/core/welford_then_ewma_mean_variance_core.sv */
// Top level of the running mean and variance core: control registers and unit wiring.
// Takes one signed 16-bit sample per transfer and returns the running mean (signed Q16.16),
// variance (unsigned Q32.16) and a fill flag. The first window_size samples use Welford's
// update, later ones an exponentially weighted update set by alpha. All multiplies and
// divides run one bit per cycle through a single shared shift-add multiplier / restoring
// divider, so an item takes up to a 32-step mean divide, a 32-step square and a 48-step
// variance divide in the fill phase, up to three 16-step and one 32-step multiply in the
// EWMA phase and none for the very first sample. The input is not ready while an item is
// in work; a finished result sits in its own register, so the next sample is taken while
// the result waits. Write csr registers only while idle.
`timescale 1ns / 1ps

module welford_then_ewma_mean_variance_core (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_ready,
   input  logic signed [wemv_pkg::SAMPLE_BITS-1:0] req_sample,
   output logic                                    rsp_valid,
   input  logic                                    rsp_ready,
   output logic signed [wemv_pkg::MEAN_BITS-1:0]   rsp_mean,
   output logic [wemv_pkg::VAR_BITS-1:0]           rsp_variance,
   output logic                                    rsp_filling,
   input  logic                                    csr_we,
   input  logic [wemv_pkg::CSR_INDEX_BITS-1:0]     csr_index,
   input  logic [wemv_pkg::CFG_BITS-1:0]           csr_wdata
);

   wemv_pkg::cfg_type     cfg_ff, cfg_in;
   wemv_pkg::alu_cmd_type alu_cmd;
   wemv_pkg::alu_res_type alu_res;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            wemv_pkg::CSR_WINDOW_SIZE: cfg_in.window_size = csr_wdata;
            wemv_pkg::CSR_ALPHA:       cfg_in.alpha       = csr_wdata;
            default:                   cfg_in             = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.window_size <= wemv_pkg::WINDOW_RESET;
         cfg_ff.alpha       <= wemv_pkg::ALPHA_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   wemv_alu u_alu (
      .clock   (clock),
      .reset   (reset),
      .alu_cmd (alu_cmd),
      .alu_res (alu_res)
   );

   wemv_ctrl u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg_ff),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_sample   (req_sample),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_mean     (rsp_mean),
      .rsp_variance (rsp_variance),
      .rsp_filling  (rsp_filling),
      .alu_cmd      (alu_cmd),
      .alu_res      (alu_res)
   );

endmodule
